/* rtl/max_priority_queue_array_macros.svh */
// Assertion macros for the max priority queue checker.
`ifndef MAX_PRIORITY_QUEUE_ARRAY_MACROS_SVH
`define MAX_PRIORITY_QUEUE_ARRAY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpq check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define MPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpq check failed");

`endif

/* rtl/mpq_pkg.sv */
// Shared types and codes for the max priority queue.
package mpq_pkg;

  localparam int unsigned WORD_BITS = 16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_PULL   = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_PULLED   = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_FINISH
  } seq_state_t;

  typedef struct packed {
    logic                 action;
    logic [WORD_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_t              status;
    logic [WORD_BITS-1:0] pulled_value;
    logic                 now_empty;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic pull;
  } scan_cmd_t;

endpackage

/* rtl/mpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mpq_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mpq_scan.sv */
// Slot sweep unit: one comparator walks the slot RAM for a max or first free slot.
module mpq_scan import mpq_pkg::*; #(
  parameter int SLOTS = 128,
  parameter int VALUE_BITS = 16,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scan_cmd_t             cmd,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [VALUE_BITS:0]   rd_data,
  output logic                  done,
  output logic                  found,
  output logic [IDX_W-1:0]      idx,
  output logic [VALUE_BITS-1:0] val
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  logic                  busy_r;
  logic                  chk_r;
  logic                  done_r;
  logic                  found_r;
  logic                  pull_r;
  logic [IDX_W-1:0]      addr_r;
  logic [IDX_W-1:0]      chk_idx_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [VALUE_BITS-1:0] best_val_r;

  logic                  used;
  logic [VALUE_BITS-1:0] dval;
  logic                  better;
  logic                  take;
  logic                  fin;

  always_comb begin
    used   = rd_data[VALUE_BITS];
    dval   = rd_data[VALUE_BITS-1:0];
    better = dval > best_val_r;
    take   = chk_r && (pull_r ? (used && (!found_r || better)) : (!used && !found_r));
    fin    = chk_r && ((!pull_r && !used) || (chk_idx_r == LAST));
  end

  assign rd_en   = busy_r;
  assign rd_addr = addr_r;
  assign done    = done_r;
  assign found   = found_r;
  assign idx     = best_idx_r;
  assign val     = best_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      chk_r   <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      done_r <= fin;
      if (cmd.start) begin
        busy_r  <= 1'b1;
        chk_r   <= 1'b0;
        found_r <= 1'b0;
        addr_r  <= '0;
        pull_r  <= cmd.pull;
      end else begin
        chk_r     <= busy_r;
        chk_idx_r <= addr_r;
        if (busy_r) begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == LAST) begin
            busy_r <= 1'b0;
          end
        end
        if (take) begin
          found_r    <= 1'b1;
          best_idx_r <= chk_idx_r;
          best_val_r <= dval;
        end
        if (fin) begin
          busy_r <= 1'b0;
          chk_r  <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/max_priority_queue_array.sv */
// Top level of the unsorted-array max priority queue.
//
//  port group   dir  word        handshake
//  in_*         in   in_word_t   in_valid / in_ready
//  out_*        out  out_word_t  out_valid / out_ready
//
// Pull: a sweep of all SLOTS slots, one slot compared per cycle through the RAM read port.
// Insert: the sweep stops at the lowest free slot.
// Pull on empty and insert on full: no sweep.
// After reset, a clearing sweep writes every slot with in_ready low.
// One word in flight; a finished result waits in the output register.
module max_priority_queue_array import mpq_pkg::*; #(
  parameter int SLOTS = 128,
  parameter int VALUE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(SLOTS);

  seq_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]      clr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  act_r;
  logic [VALUE_BITS-1:0] val_r;
  out_word_t             pend_r;
  out_word_t             out_data_r;
  logic                  out_valid_r;

  logic                  accept;
  logic                  quick;
  logic                  release_out;
  scan_cmd_t             cmd;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [VALUE_BITS:0]   ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [VALUE_BITS:0]   ram_rdata;
  logic                  scan_done;
  logic                  scan_found;
  logic [IDX_W-1:0]      scan_idx;
  logic [VALUE_BITS-1:0] scan_val;

  assign accept      = in_valid && in_ready;
  assign quick       = (in_data.action == ACT_PULL) ? (cnt_r == '0) : (cnt_r == FULL);
  assign release_out = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_CLEAR: begin
        if (clr_r == LAST) state_nxt = SEQ_IDLE;
      end
      SEQ_IDLE: begin
        if (accept) state_nxt = quick ? SEQ_FINISH : SEQ_SCAN;
      end
      SEQ_SCAN: begin
        if (scan_done) state_nxt = SEQ_FINISH;
      end
      SEQ_FINISH: begin
        if (release_out) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.start = 1'b0;
    cmd.pull  = in_data.action == ACT_PULL;
    ram_we    = 1'b0;
    ram_waddr = scan_idx;
    ram_wdata = {act_r == ACT_INSERT, val_r};
    unique case (state_r)
      SEQ_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      SEQ_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid && !quick;
      end
      SEQ_SCAN: begin
        ram_we = scan_done;
      end
      SEQ_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == SEQ_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (accept) begin
        act_r <= in_data.action;
        val_r <= VALUE_BITS'(in_data.value);
        if (in_data.action == ACT_PULL) begin
          pend_r <= '{status: STAT_EMPTY, pulled_value: '0, now_empty: 1'b1};
        end else begin
          pend_r <= '{status: STAT_FULL, pulled_value: '0, now_empty: cnt_r == '0};
        end
      end
      if (state_r == SEQ_SCAN && scan_done) begin
        if (act_r == ACT_INSERT) begin
          cnt_r  <= cnt_r + 1'b1;
          pend_r <= '{status: STAT_INSERTED, pulled_value: '0, now_empty: 1'b0};
        end else begin
          cnt_r  <= cnt_r - 1'b1;
          pend_r <= '{status: STAT_PULLED, pulled_value: WORD_BITS'(scan_val),
                      now_empty: cnt_r == CNT_W'(1)};
        end
      end
      if (state_r == SEQ_FINISH && release_out) begin
        out_valid_r <= 1'b1;
        out_data_r  <= pend_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mpq_scan #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .done    (scan_done),
    .found   (scan_found),
    .idx     (scan_idx),
    .val     (scan_val)
  );

  mpq_ram #(
    .WIDTH (VALUE_BITS + 1),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we && (state_r == SEQ_CLEAR || act_r == ACT_INSERT || scan_found)),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/mpq_checker.sv */
// Port-level checker for the max priority queue, bound to the top level.
`include "max_priority_queue_array_macros.svh"

module mpq_checker import mpq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  `MPQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `MPQ_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))
  `MPQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `MPQ_ASSERT_IMP(a_empty_word, out_valid && out_data.status == STAT_EMPTY,
                  out_data.now_empty && out_data.pulled_value == '0)
  `MPQ_ASSERT_IMP(a_insert_word, out_valid && out_data.status == STAT_INSERTED,
                  !out_data.now_empty && out_data.pulled_value == '0)

endmodule

bind max_priority_queue_array mpq_checker u_mpq_checker (.*);
